// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL of the buzzer sequencer core.
// Each macro checks on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Types, codes, reset values and the step tables of the buzzer patterns.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int MAX_STEPS = 5;

    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic       ACTIVE_LEVEL_RESET = 1'b1;
    localparam logic [9:0] IDLE_WAIT_RESET    = 10'd100;
    localparam logic [7:0] SLICE_RESET        = 8'd20;

    localparam logic [3:0] PAT_OFF    = 4'd0;
    localparam logic [3:0] PAT_ARMED  = 4'd9;
    localparam logic [3:0] PAT_FIRING = 4'd10;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PLAY   = 2'd1,
        OP_SET_BG = 2'd2,
        OP_STOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_IDLE_WAIT    = 2'd1,
        REG_SLICE        = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_FORE = 3'b010,
        PH_BACK = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  pat;
        logic [2:0]  idx;
        logic [10:0] step_left;
        logic [7:0]  slice_left;
        logic [9:0]  idle_left;
    } t_seq;

    // Number of table steps of a pattern.
    function automatic logic [3:0] tone_len(input logic [3:0] pat);
        logic [3:0] len;
        unique case (pat)
            4'd1, 4'd4, 4'd5:        len = 4'd1;
            4'd2:                    len = 4'd3;
            4'd3, 4'd6:              len = 4'd5;
            4'd7, 4'd8, 4'd9, 4'd10: len = 4'd2;
            default:                 len = 4'd0;
        endcase
        return len;
    endfunction

    // Steps actually played, clipped to MAX_STEPS.
    function automatic logic [3:0] tone_steps(input logic [3:0] pat);
        logic [3:0] len;
        len = tone_len(pat);
        return (len > 4'(MAX_STEPS)) ? 4'(MAX_STEPS) : len;
    endfunction

    function automatic logic tone_loops(input logic [3:0] pat);
        return (pat >= 4'd7) && (pat <= 4'd10);
    endfunction

    // Every pattern starts sounding and alternates on and off.
    function automatic logic tone_on(input logic [3:0] pat, input logic [2:0] idx);
        return ({1'b0, idx} < tone_len(pat)) && !idx[0];
    endfunction

    function automatic logic [10:0] tone_dur(input logic [3:0] pat, input logic [2:0] idx);
        logic [10:0] on_ms;
        logic [10:0] off_ms;
        unique case (pat)
            4'd1, 4'd2: begin on_ms = 11'd100; off_ms = 11'd100;  end
            4'd3:       begin on_ms = 11'd100; off_ms = 11'd80;   end
            4'd4:       begin on_ms = 11'd500; off_ms = 11'd0;    end
            4'd5:       begin on_ms = 11'd80;  off_ms = 11'd0;    end
            4'd6:       begin on_ms = 11'd200; off_ms = 11'd100;  end
            4'd7:       begin on_ms = 11'd200; off_ms = 11'd200;  end
            4'd8:       begin on_ms = 11'd100; off_ms = 11'd100;  end
            4'd9:       begin on_ms = 11'd80;  off_ms = 11'd1120; end
            4'd10:      begin on_ms = 11'd90;  off_ms = 11'd160;  end
            default:    begin on_ms = 11'd0;   off_ms = 11'd0;    end
        endcase
        if ({1'b0, idx} >= tone_len(pat)) begin
            return 11'd0;
        end
        return idx[0] ? off_ms : on_ms;
    endfunction

endpackage
`default_nettype wire

// ===== design/buzzer_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result of an item is registered in the output register as the item is taken.
// Throughput: one item per cycle, set by the single result register, which keeps
// taking items as long as the downstream side takes results.
// Reset (i_rst_n low, synchronous): idle, background off, idle wait 100 ticks, registers at
// active level 1, idle wait 100 ms, slice 20 ms; no result pending.
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer core
// Steps a buzzer pin through on/off tables of foreground beeps and alarms and a background
// tone, one millisecond tick per tick item, with one status result per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buzzer_pattern_sequencer_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input items
    input  wire logic                               i_s_axis_tvalid,
    output      logic                               o_s_axis_tready,
    input  wire logic [bps_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // [3:0] pattern
    input  wire logic [bps_pkg::IN_USER_W-1:0]      i_s_axis_tuser,  // [1:0] opcode
    // Results
    output      logic                               o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [0] pin_level, [4:1] sounding_pattern, [5] in_background
    output      logic [bps_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // Configuration writes
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [bps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bps_pkg::*;

    logic       r_active_level;
    logic [9:0] r_idle_wait;
    logic [7:0] r_slice;

    t_seq       r_st;
    t_seq       n_st;
    logic [3:0] r_bg;
    logic [3:0] n_bg;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic       s_fire;
    t_opcode    in_op;
    logic [3:0] in_pat;
    logic [9:0] idle_eff;
    logic [7:0] slice_eff;

    function automatic logic [7:0] f_min_slice(input logic [10:0] left, input logic [7:0] s);
        return (left < {3'b000, s}) ? left[7:0] : s;
    endfunction

    function automatic t_seq f_idle(input t_seq s, input logic [9:0] iw);
        t_seq o;
        o            = s;
        o.phase      = PH_IDLE;
        o.pat        = PAT_OFF;
        o.idx        = 3'd0;
        o.step_left  = 11'd0;
        o.slice_left = 8'd0;
        o.idle_left  = iw;
        return o;
    endfunction

    function automatic t_seq f_start_bg(input t_seq s, input logic [3:0] bg,
                                        input logic [7:0] se);
        t_seq o;
        o            = s;
        o.phase      = PH_BACK;
        o.pat        = bg;
        o.idx        = 3'd0;
        o.step_left  = tone_dur(bg, 3'd0);
        o.slice_left = f_min_slice(o.step_left, se);
        return o;
    endfunction

    function automatic logic f_bg_ok(input logic [3:0] bg);
        return (bg == PAT_ARMED) || (bg == PAT_FIRING);
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign s_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op     = t_opcode'(i_s_axis_tuser[1:0]);
    assign in_pat    = i_s_axis_tdata[3:0];
    assign idle_eff  = (r_idle_wait == 10'd0) ? 10'd1 : r_idle_wait;
    assign slice_eff = (r_slice == 8'd0) ? 8'd1 : r_slice;

    always_comb begin
        logic [10:0] t_left;
        logic [7:0]  s_left;
        logic [9:0]  w_left;
        logic [3:0]  inc;
        logic        on;
        logic        active;

        n_st   = r_st;
        n_bg   = r_bg;
        t_left = (r_st.step_left != 11'd0) ? r_st.step_left - 11'd1 : 11'd0;
        s_left = (r_st.slice_left != 8'd0) ? r_st.slice_left - 8'd1 : 8'd0;
        w_left = (r_st.idle_left != 10'd0) ? r_st.idle_left - 10'd1 : 10'd0;
        inc    = {1'b0, r_st.idx} + 4'd1;

        unique case (in_op)
            OP_STOP: begin
                n_bg = PAT_OFF;
                n_st = f_idle(r_st, idle_eff);
            end
            OP_SET_BG: begin
                n_bg = in_pat;
            end
            OP_PLAY: begin
                if (tone_steps(in_pat) != 4'd0) begin
                    n_st.phase      = PH_FORE;
                    n_st.pat        = in_pat;
                    n_st.idx        = 3'd0;
                    n_st.step_left  = tone_dur(in_pat, 3'd0);
                    n_st.slice_left = 8'd0;
                end else if (f_bg_ok(r_bg)) begin
                    n_st = f_start_bg(r_st, r_bg, slice_eff);
                end else begin
                    n_st = f_idle(r_st, idle_eff);
                end
            end
            OP_TICK: begin
                unique case (r_st.phase)
                    PH_FORE: begin
                        n_st.step_left = t_left;
                        if (t_left == 11'd0) begin
                            if (inc >= tone_steps(r_st.pat)) begin
                                if (tone_loops(r_st.pat)) begin
                                    n_st.idx       = 3'd0;
                                    n_st.step_left = tone_dur(r_st.pat, 3'd0);
                                end else if (f_bg_ok(r_bg)) begin
                                    n_st = f_start_bg(r_st, r_bg, slice_eff);
                                end else begin
                                    n_st = f_idle(r_st, idle_eff);
                                end
                            end else begin
                                n_st.idx       = inc[2:0];
                                n_st.step_left = tone_dur(r_st.pat, inc[2:0]);
                            end
                        end
                    end
                    PH_BACK: begin
                        n_st.step_left  = t_left;
                        n_st.slice_left = s_left;
                        // The background register is only looked at on a slice boundary.
                        if (s_left == 8'd0) begin
                            if (r_bg != r_st.pat) begin
                                n_st = f_idle(r_st, idle_eff);
                            end else if (t_left == 11'd0) begin
                                n_st.idx        = (inc >= tone_steps(r_st.pat)) ? 3'd0
                                                                                : inc[2:0];
                                n_st.step_left  = tone_dur(r_st.pat, n_st.idx);
                                n_st.slice_left = f_min_slice(n_st.step_left, slice_eff);
                            end else begin
                                n_st.slice_left = f_min_slice(t_left, slice_eff);
                            end
                        end
                    end
                    default: begin
                        n_st.idle_left = w_left;
                        if (w_left == 10'd0) begin
                            if (f_bg_ok(r_bg)) begin
                                n_st = f_start_bg(r_st, r_bg, slice_eff);
                            end else begin
                                n_st.idle_left = idle_eff;
                            end
                        end
                    end
                endcase
            end
            default: begin
                n_st = r_st;
            end
        endcase

        active = (n_st.phase == PH_FORE) || (n_st.phase == PH_BACK);
        on     = active && tone_on(n_st.pat, n_st.idx);
        n_out_data = {2'b00,
                      (n_st.phase == PH_BACK),
                      active ? n_st.pat : PAT_OFF,
                      on ? r_active_level : !r_active_level};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= ACTIVE_LEVEL_RESET;
            r_idle_wait    <= IDLE_WAIT_RESET;
            r_slice        <= SLICE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[0];
                REG_IDLE_WAIT:    r_idle_wait    <= i_cfg_data[9:0];
                REG_SLICE:        r_slice        <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase      <= PH_IDLE;
            r_st.pat        <= PAT_OFF;
            r_st.idx        <= 3'd0;
            r_st.step_left  <= 11'd0;
            r_st.slice_left <= 8'd0;
            r_st.idle_left  <= IDLE_WAIT_RESET;
            r_bg            <= PAT_OFF;
            r_out_valid     <= 1'b0;
        end else if (s_fire) begin
            r_st        <= n_st;
            r_bg        <= n_bg;
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= n_out_data;
        end
    end

    `ASSERT_ALWAYS(a_idle_silent, (r_st.phase != PH_IDLE) || (r_st.pat == PAT_OFF),
        "idle sequencer holds a pattern")
    `ASSERT_ALWAYS(a_fore_step_live, (r_st.phase != PH_FORE) || (r_st.step_left != 11'd0),
        "foreground step with no time left")
    `ASSERT_ALWAYS(a_back_slice_ok, (r_st.phase != PH_BACK) ||
        ((r_st.slice_left != 8'd0) && ({3'b000, r_st.slice_left} <= r_st.step_left)),
        "background slice out of range")
    `ASSERT_NEXT(a_stop_idles, s_fire && (in_op == OP_STOP),
        (r_st.phase == PH_IDLE) && (r_bg == PAT_OFF) && o_m_axis_tvalid,
        "stop did not silence the sequencer")

endmodule
`default_nettype wire

// ===== verif/bps_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer sequencer status checker
// Watches the item, status and register channels of the sequencer core, keeps
// its own model of the pattern tables and sequencing state, and compares every
// status transfer against the oldest predicted status.
// ----------------------------------------------------------------------------
module bps_status_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [bps_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // [3:0] pattern
    input  logic [bps_pkg::IN_USER_W-1:0]   i_s_axis_tuser,  // [1:0] opcode
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] pin_level, [4:1] sounding_pattern, [5] in_background
    input  logic [bps_pkg::OUT_DATA_W-1:0]  i_m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [31:0]                     o_errors,
    output logic [31:0]                     o_pending
);
    import bps_pkg::*;

    localparam logic [3:0] PAT_SHORT     = 4'd1;
    localparam logic [3:0] PAT_DOUBLE    = 4'd2;
    localparam logic [3:0] PAT_TRIPLE    = 4'd3;
    localparam logic [3:0] PAT_LONG      = 4'd4;
    localparam logic [3:0] PAT_PING_FAIL = 4'd5;
    localparam logic [3:0] PAT_CONT_LOST = 4'd6;
    localparam logic [3:0] PAT_LINK_LOST = 4'd7;
    localparam logic [3:0] PAT_CRITICAL  = 4'd8;

    // Register copies.
    logic       lvl_cfg;
    logic [9:0] idle_cfg;
    logic [7:0] slice_cfg;

    // Sequencing state.
    t_phase      ph;
    logic [3:0]  cur_pat;
    logic [2:0]  cur_idx;
    logic [10:0] step_left;
    logic [3:0]  bg_pat;
    logic [9:0]  idle_left;
    logic [7:0]  slice_left;

    logic [7:0] status_q[$];
    int         err_cnt = 0;

    function automatic logic [3:0] tbl_len(input logic [3:0] p);
        case (p)
            PAT_SHORT, PAT_LONG, PAT_PING_FAIL:                return 4'd1;
            PAT_DOUBLE:                                        return 4'd3;
            PAT_TRIPLE, PAT_CONT_LOST:                         return 4'd5;
            PAT_LINK_LOST, PAT_CRITICAL, PAT_ARMED, PAT_FIRING: return 4'd2;
            default:                                           return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] steps_used(input logic [3:0] p);
        logic [3:0] n;
        n = tbl_len(p);
        return (n > 4'(MAX_STEPS)) ? 4'(MAX_STEPS) : n;
    endfunction

    // Every table alternates sounding and silent steps, starting with a sounding one.
    function automatic logic step_sounds(input logic [3:0] p, input logic [2:0] k);
        return ({1'b0, k} < tbl_len(p)) && !k[0];
    endfunction

    function automatic logic [10:0] step_ms(input logic [3:0] p, input logic [2:0] k);
        logic [10:0] on_ms;
        logic [10:0] off_ms;
        case (p)
            PAT_SHORT, PAT_DOUBLE, PAT_CRITICAL: begin on_ms = 11'd100; off_ms = 11'd100; end
            PAT_TRIPLE:    begin on_ms = 11'd100; off_ms = 11'd80;   end
            PAT_LONG:      begin on_ms = 11'd500; off_ms = 11'd0;    end
            PAT_PING_FAIL: begin on_ms = 11'd80;  off_ms = 11'd0;    end
            PAT_CONT_LOST: begin on_ms = 11'd200; off_ms = 11'd100;  end
            PAT_LINK_LOST: begin on_ms = 11'd200; off_ms = 11'd200;  end
            PAT_ARMED:     begin on_ms = 11'd80;  off_ms = 11'd1120; end
            PAT_FIRING:    begin on_ms = 11'd90;  off_ms = 11'd160;  end
            default:       begin on_ms = 11'd0;   off_ms = 11'd0;    end
        endcase
        if ({1'b0, k} >= tbl_len(p)) begin
            return 11'd0;
        end
        return k[0] ? off_ms : on_ms;
    endfunction

    // A zero slice register acts as one tick.
    function automatic logic [7:0] slice_reload();
        logic [7:0] s;
        s = (slice_cfg == 8'd0) ? 8'd1 : slice_cfg;
        return (step_left < {3'b000, s}) ? step_left[7:0] : s;
    endfunction

    task automatic load_step();
        step_left  = step_ms(cur_pat, cur_idx);
        slice_left = (ph == PH_BACK) ? slice_reload() : 8'd0;
    endtask

    task automatic go_idle();
        ph         = PH_IDLE;
        cur_pat    = PAT_OFF;
        cur_idx    = 3'd0;
        step_left  = 11'd0;
        slice_left = 8'd0;
        idle_left  = (idle_cfg == 10'd0) ? 10'd1 : idle_cfg;
    endtask

    task automatic start_bg();
        ph      = PH_BACK;
        cur_pat = bg_pat;
        cur_idx = 3'd0;
        load_step();
    endtask

    task automatic finish_fore();
        if (bg_pat == PAT_ARMED || bg_pat == PAT_FIRING) begin
            start_bg();
        end else begin
            go_idle();
        end
    endtask

    task automatic advance_sequencer(input t_opcode op, input logic [3:0] pat,
                                     output logic [7:0] status);
        logic playing;
        case (op)
            OP_TICK: begin
                case (ph)
                    PH_FORE: begin
                        if (step_left != 0) step_left--;
                        if (step_left == 0) begin
                            cur_idx++;
                            if ({1'b0, cur_idx} >= steps_used(cur_pat)) begin
                                if (cur_pat >= PAT_LINK_LOST && cur_pat <= PAT_FIRING) begin
                                    cur_idx = 3'd0;
                                    load_step();
                                end else begin
                                    finish_fore();
                                end
                            end else begin
                                load_step();
                            end
                        end
                    end
                    PH_BACK: begin
                        if (step_left != 0) step_left--;
                        if (slice_left != 0) slice_left--;
                        // A changed background is only noticed when a slice runs out.
                        if (slice_left == 0) begin
                            if (bg_pat != cur_pat) begin
                                go_idle();
                            end else if (step_left == 0) begin
                                cur_idx++;
                                if ({1'b0, cur_idx} >= steps_used(cur_pat)) cur_idx = 3'd0;
                                load_step();
                            end else begin
                                slice_left = slice_reload();
                            end
                        end
                    end
                    default: begin
                        if (idle_left != 0) idle_left--;
                        if (idle_left == 0) begin
                            if (bg_pat == PAT_ARMED || bg_pat == PAT_FIRING) begin
                                start_bg();
                            end else begin
                                idle_left = (idle_cfg == 10'd0) ? 10'd1 : idle_cfg;
                            end
                        end
                    end
                endcase
            end
            OP_PLAY: begin
                if (pat >= PAT_SHORT && pat <= PAT_FIRING && steps_used(pat) != 0) begin
                    ph      = PH_FORE;
                    cur_pat = pat;
                    cur_idx = 3'd0;
                    load_step();
                end else begin
                    finish_fore();
                end
            end
            OP_SET_BG: bg_pat = pat;
            default: begin
                bg_pat = PAT_OFF;
                go_idle();
            end
        endcase
        playing = (ph == PH_FORE) || (ph == PH_BACK);
        status  = {2'b00, ph == PH_BACK, playing ? cur_pat : PAT_OFF,
                   (playing && step_sounds(cur_pat, cur_idx)) ? lvl_cfg : ~lvl_cfg};
    endtask

    always @(posedge i_clk) begin : watch
        logic [7:0] want;
        logic [7:0] got;
        if (!i_rst_n) begin
            lvl_cfg    = ACTIVE_LEVEL_RESET;
            idle_cfg   = IDLE_WAIT_RESET;
            slice_cfg  = SLICE_RESET;
            ph         = PH_IDLE;
            cur_pat    = PAT_OFF;
            cur_idx    = 3'd0;
            step_left  = 11'd0;
            bg_pat     = PAT_OFF;
            idle_left  = IDLE_WAIT_RESET;
            slice_left = 8'd0;
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_LEVEL: lvl_cfg   = i_cfg_data[0];
                    REG_IDLE_WAIT:    idle_cfg  = i_cfg_data[9:0];
                    REG_SLICE:        slice_cfg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // The status register holds earlier results only, so check before predicting.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (status_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected status: got pin %0b pat %0d bg %0b",
                             $time, got[0], got[4:1], got[5]);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display("%0t: mismatch: expected pin %0b pat %0d bg %0b pad %0h",
                                 $time, want[0], want[4:1], want[5], want[7:6]);
                        $display("    got pin %0b pat %0d bg %0b pad %0h",
                                 got[0], got[4:1], got[5], got[7:6]);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_sequencer(t_opcode'(i_s_axis_tuser), i_s_axis_tdata[3:0], want);
                status_q.push_back(want);
            end
        end
        o_errors  <= err_cnt;
        o_pending <= status_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer testbench
// Drives ticks, play requests, background changes and stops into the core
// under four register settings and four flow-control phases, while the status
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import bps_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int N_PHASES   = 4;
    localparam int RAND_ITEMS = 356;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata;
    logic [IN_USER_W-1:0]   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [31:0] chk_errors;
    logic [31:0] chk_pending;

    int src_pct_tbl[N_PHASES]  = '{0, 49, 0, 10};
    int sink_pct_tbl[N_PHASES] = '{0, 0, 49, 10};
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;

    buzzer_pattern_sequencer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bps_status_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Status receiver: stalls at random according to the current phase.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic drive_item(input t_opcode op, input logic [3:0] pat);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0000, pat};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every predicted status has been taken.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly a request followed by a run of ticks, so patterns get to play out.
    task automatic run_random(input int budget);
        int left;
        int ticks;
        int r;
        logic [3:0] pat;
        left = budget;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    pat = ($urandom_range(0, 4) == 0) ? PAT_OFF : 4'($urandom_range(11, 15));
                end else begin
                    pat = 4'($urandom_range(1, 10));
                end
                drive_item(OP_PLAY, pat);
            end else if (r < 92) begin
                if ($urandom_range(0, 3) == 0) begin
                    pat = 4'($urandom_range(0, 15));
                end else begin
                    pat = $urandom_range(0, 1) ? PAT_ARMED : PAT_FIRING;
                end
                drive_item(OP_SET_BG, pat);
            end else begin
                drive_item(OP_STOP, 4'($urandom_range(0, 15)));
            end
            left--;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                ticks = 0;
            end else if (r < 60) begin
                ticks = $urandom_range(1, 20);
            end else if (r < 90) begin
                ticks = $urandom_range(21, 120);
            end else begin
                ticks = $urandom_range(121, 320);
            end
            if (ticks > left) ticks = left;
            repeat (ticks) drive_item(OP_TICK, 4'($urandom_range(0, 15)));
            left -= ticks;
        end
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_TICK;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_ACTIVE_LEVEL;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase_n = 0; phase_n < N_PHASES; phase_n++) begin
            src_idle_pct   = src_pct_tbl[phase_n];
            sink_stall_pct = sink_pct_tbl[phase_n];
            case (phase_n)
                0: begin
                    // Reset register values; directed walk through the corner cases.
                    drive_item(OP_TICK, PAT_OFF);
                    drive_item(OP_SET_BG, PAT_ARMED);
                    drive_item(OP_PLAY, PAT_OFF);      // armed background starts at once
                    drive_item(OP_TICK, PAT_OFF);
                    drive_item(OP_SET_BG, PAT_FIRING); // change during background play
                    drive_item(OP_TICK, '1);
                    drive_item(OP_PLAY, 4'd2);
                    drive_item(OP_SET_BG, 4'd1);       // stored only, never sounds
                    drive_item(OP_TICK, PAT_OFF);
                    drive_item(OP_PLAY, '1);           // unknown pattern
                    drive_item(OP_STOP, '1);
                    for (int p = 1; p <= 8; p++) drive_item(OP_PLAY, 4'(p));
                    drive_item(OP_PLAY, PAT_ARMED);
                    drive_item(OP_PLAY, PAT_FIRING);
                    drive_item(OP_PLAY, PAT_FIRING + 4'd1);
                    drive_item(OP_SET_BG, '1);
                    drive_item(OP_TICK, PAT_OFF);
                    drive_item(OP_STOP, PAT_OFF);
                end
                1: begin
                    // Zero idle wait and slice behave as one tick.
                    write_reg(REG_ACTIVE_LEVEL, '0);
                    write_reg(REG_IDLE_WAIT, '0);
                    write_reg(REG_SLICE, '0);
                end
                2: begin
                    write_reg(REG_ACTIVE_LEVEL, 10'd1);
                    write_reg(REG_IDLE_WAIT, 10'd1023);
                    write_reg(REG_SLICE, 10'd255);
                end
                default: begin
                    write_reg(REG_UNUSED, 10'($urandom_range(0, 1023)));
                    write_reg(REG_ACTIVE_LEVEL, 10'($urandom_range(0, 1023)));
                    write_reg(REG_IDLE_WAIT, 10'($urandom_range(1, 40)));
                    write_reg(REG_SLICE, {2'($urandom_range(0, 3)), 8'($urandom_range(1, 30))});
                end
            endcase
            run_random(RAND_ITEMS);
            drain();
        end

        $display("Covered %0d items in %0d flow-control phases with reset, zero,",
                 items_sent, N_PHASES);
        $display("full-scale and random registers; %0d mismatches, %0d statuses pending.",
                 chk_errors, chk_pending);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
